// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/tsq_pkg.sv =====
// ---------------------------------------------------------------------------
// tsq_pkg
// shared types, widths and constants of the square tone sequencer
// ---------------------------------------------------------------------------
package tsq_pkg;

	localparam int COUNT_BITS = 20;

	localparam int RATE_W = 18;
	localparam int AMP_W  = 15;
	localparam int MID_W  = 16;
	localparam int MAXS_W = 20;
	localparam int FREQ_W = 16;
	localparam int MS_W   = 16;
	localparam int CFG_W  = 20;
	localparam int ADDR_W = 2;

	localparam int PER_W  = 18;
	localparam int HALF_W = 17;
	localparam int CMP_W  = (COUNT_BITS > MAXS_W) ? COUNT_BITS : MAXS_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// serial multiplier: sample_rate by step length in ms
	localparam int MUL_A_W   = RATE_W;
	localparam int MUL_B_W   = MS_W;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// serial restoring divider
	localparam int DIV_W     = PROD_W;
	localparam int DIVR_W    = PER_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [DIVR_W-1:0] MS_PER_S = DIVR_W'(1000);
	localparam logic [PER_W-1:0]  MIN_PER  = PER_W'(2);

	localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(80000);
	localparam logic [AMP_W-1:0]  AMP_RST  = AMP_W'(8000);
	localparam logic [MID_W-1:0]  MID_RST  = MID_W'(32768);
	localparam logic [MAXS_W-1:0] MAXS_RST = {MAXS_W{1'b1}};

	typedef enum logic [ADDR_W-1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_AMPLITUDE   = 2'd1,
		REG_MIDPOINT    = 2'd2,
		REG_MAX_SAMPLES = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_STEP = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NDIV,
		ST_PDIV,
		ST_PHDIV
	} state_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] product;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quotient;
		logic [DIVR_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== src/tsq_sermul.sv =====
// ---------------------------------------------------------------------------
// tsq_sermul
// shift-add multiplier, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module tsq_sermul (
	input  logic              clk,
	input  logic              arst_n,
	input  tsq_pkg::mul_req_t req,
	output tsq_pkg::mul_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [tsq_pkg::MUL_CNT_W-1:0]    cnt_q;
	logic [tsq_pkg::MUL_A_W-1:0]      a_q;
	logic [tsq_pkg::PROD_W-1:0]       prod_q;
	logic [tsq_pkg::MUL_A_W:0]        sum;

	// upper half accumulates, lower half holds the multiplier bits still to come
	always_comb begin
		sum = {1'b0, prod_q[tsq_pkg::PROD_W-1:tsq_pkg::MUL_B_W]}
			+ (prod_q[0] ? {1'b0, a_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tsq_pkg::MUL_CNT_W'(tsq_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a;
			prod_q <= {{tsq_pkg::MUL_A_W{1'b0}}, req.b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[tsq_pkg::MUL_B_W-1:1]};
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = prod_q;

endmodule

// ===== src/tsq_serdiv.sv =====
// ---------------------------------------------------------------------------
// tsq_serdiv
// restoring divider, one quotient bit per cycle, shared by all step divisions
// ---------------------------------------------------------------------------
module tsq_serdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  tsq_pkg::div_req_t req,
	output tsq_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [tsq_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [tsq_pkg::DIVR_W-1:0]    dvs_q;
	logic [tsq_pkg::DIV_W-1:0]     dvd_q;
	logic [tsq_pkg::DIVR_W-1:0]    rem_q;
	logic [tsq_pkg::DIVR_W:0]      rem_w;
	logic [tsq_pkg::DIVR_W:0]      rem_sub;
	logic                          ge;

	always_comb begin
		rem_w   = {rem_q, dvd_q[tsq_pkg::DIV_W-1]};
		ge      = (rem_w >= {1'b0, dvs_q});
		rem_sub = rem_w - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tsq_pkg::DIV_CNT_W'(tsq_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tsq_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[tsq_pkg::DIVR_W-1:0] : rem_w[tsq_pkg::DIVR_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== src/square_tone_sequencer.sv =====
// ---------------------------------------------------------------------------
// square_tone_sequencer
// square-wave tone sequencer: step items set up a tone, tick items emit samples
// ---------------------------------------------------------------------------
//  channel   direction  payload                                  handshake
//  s_axis    in         tuser: kind, restart; tdata: freq, ms    tvalid/tready
//  m_axis    out        tdata: sample; tuser: active, full       tvalid/tready
//  cfg       in         cfg_addr register index, cfg_wdata       cfg_we
//
//  a tick item gives one result item straight into the output register
//  a step item holds the input through the shift-add multiplier, then up to three
//  passes through the shared restoring divider (length, period, phase); a skipped
//  or silent step ends after the first division
//  s_axis is not ready during a step and while a result waits on a stalled m_axis
//  reset clears counters, step state and registers to their defaults at once
// ---------------------------------------------------------------------------
module square_tone_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // freq_hz, step_ms
	input  logic [1:0]                  s_axis_tuser,  // kind, restart
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [15:0]                 m_axis_tdata,  // sample
	output logic [1:0]                  m_axis_tuser,  // active, budget_full
	input  logic                        cfg_we,
	input  logic [tsq_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [tsq_pkg::CFG_W-1:0]   cfg_wdata
);

	// configuration
	logic [tsq_pkg::RATE_W-1:0] rate_q;
	logic [tsq_pkg::AMP_W-1:0]  amp_q;
	logic [tsq_pkg::MID_W-1:0]  mid_q;
	logic [tsq_pkg::MAXS_W-1:0] maxs_q;

	// sequence and step state
	tsq_pkg::state_t                  state_q, state_d;
	logic [tsq_pkg::COUNT_BITS-1:0]   idx_q;
	logic [tsq_pkg::COUNT_BITS-1:0]   remain_q;
	logic [tsq_pkg::PER_W-1:0]        period_q;
	logic [tsq_pkg::HALF_W-1:0]       half_q;
	logic [tsq_pkg::PER_W-1:0]        phase_q;
	logic                             silent_q;
	logic [tsq_pkg::FREQ_W-1:0]       freq_q;
	logic [tsq_pkg::COUNT_BITS-1:0]   nstep_q;
	logic [tsq_pkg::PER_W-1:0]        per_new_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic        out_active_q;
	logic        out_full_q;

	tsq_pkg::mul_req_t mul_req;
	tsq_pkg::mul_rsp_t mul_rsp;
	tsq_pkg::div_req_t div_req;
	tsq_pkg::div_rsp_t div_rsp;

	logic                        in_acc;
	logic                        kind_tick;
	logic                        restart;
	logic [tsq_pkg::FREQ_W-1:0]  in_freq;
	logic [tsq_pkg::MS_W-1:0]    in_ms;

	logic [tsq_pkg::CMP_W-1:0]      limit;
	logic [tsq_pkg::CMP_W-1:0]      idx_ext;
	logic [tsq_pkg::CMP_W-1:0]      budget;
	logic [tsq_pkg::DIV_W-1:0]      budget_ext;
	logic [tsq_pkg::COUNT_BITS-1:0] n_clip;
	logic                           n_zero;
	logic [tsq_pkg::PER_W-1:0]      per_cl;

	logic [tsq_pkg::MID_W:0]        up_sum;
	logic [tsq_pkg::MID_W:0]        dn_sum;
	logic [15:0]                    tick_sample;
	logic                           tick_active;
	logic [tsq_pkg::COUNT_BITS-1:0] idx_next;
	logic                           tick_full;
	logic [tsq_pkg::PER_W-1:0]      phase_inc;

	assign kind_tick     = (s_axis_tuser[0] == tsq_pkg::KIND_TICK);
	assign restart       = s_axis_tuser[1];
	assign in_freq       = s_axis_tdata[15:0];
	assign in_ms         = s_axis_tdata[31:16];
	assign s_axis_tready = (state_q == tsq_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// budget left, clipped step length and clamped period
	always_comb begin
		limit = (tsq_pkg::CMP_W'(maxs_q) > tsq_pkg::CMP_W'(tsq_pkg::COUNT_MAX))
			? tsq_pkg::CMP_W'(tsq_pkg::COUNT_MAX) : tsq_pkg::CMP_W'(maxs_q);
		idx_ext    = tsq_pkg::CMP_W'(idx_q);
		budget     = (limit > idx_ext) ? (limit - idx_ext) : '0;
		budget_ext = tsq_pkg::DIV_W'(budget);
		n_clip     = (div_rsp.quotient > budget_ext)
			? tsq_pkg::COUNT_BITS'(budget) : div_rsp.quotient[tsq_pkg::COUNT_BITS-1:0];
		n_zero     = (n_clip == '0);
		per_cl     = (div_rsp.quotient[tsq_pkg::PER_W-1:0] < tsq_pkg::MIN_PER)
			? tsq_pkg::MIN_PER : div_rsp.quotient[tsq_pkg::PER_W-1:0];
	end

	// tick result
	always_comb begin
		up_sum    = {1'b0, mid_q} + {2'b00, amp_q};
		dn_sum    = {1'b0, mid_q} - {2'b00, amp_q};
		phase_inc = phase_q + 1'b1;
		if (remain_q == '0) begin
			tick_sample = mid_q;
			tick_active = 1'b0;
			idx_next    = idx_q;
		end else begin
			tick_active = 1'b1;
			idx_next    = (idx_q < tsq_pkg::COUNT_MAX) ? idx_q + 1'b1 : idx_q;
			if (silent_q) begin
				tick_sample = mid_q;
			end else if (phase_q < tsq_pkg::PER_W'(half_q)) begin
				tick_sample = up_sum[tsq_pkg::MID_W] ? 16'hFFFF : up_sum[15:0];
			end else begin
				// borrow out means the swing went below zero
				tick_sample = dn_sum[tsq_pkg::MID_W] ? 16'h0000 : dn_sum[15:0];
			end
		end
		tick_full = (tsq_pkg::CMP_W'(idx_next) >= tsq_pkg::CMP_W'(maxs_q));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsq_pkg::ST_IDLE: begin
				if (in_acc && !kind_tick) state_d = tsq_pkg::ST_MUL;
			end
			tsq_pkg::ST_MUL: begin
				if (mul_rsp.done) state_d = tsq_pkg::ST_NDIV;
			end
			tsq_pkg::ST_NDIV: begin
				if (div_rsp.done) begin
					state_d = (n_zero || freq_q == '0) ? tsq_pkg::ST_IDLE : tsq_pkg::ST_PDIV;
				end
			end
			tsq_pkg::ST_PDIV: begin
				if (div_rsp.done) state_d = tsq_pkg::ST_PHDIV;
			end
			tsq_pkg::ST_PHDIV: begin
				if (div_rsp.done) state_d = tsq_pkg::ST_IDLE;
			end
			default: state_d = tsq_pkg::ST_IDLE;
		endcase
	end

	// unit requests
	always_comb begin
		mul_req.start    = 1'b0;
		mul_req.a        = rate_q;
		mul_req.b        = in_ms;
		div_req.start    = 1'b0;
		div_req.dividend = mul_rsp.product;
		div_req.divisor  = tsq_pkg::MS_PER_S;
		unique case (state_q)
			tsq_pkg::ST_IDLE: begin
				mul_req.start = in_acc && !kind_tick;
			end
			tsq_pkg::ST_MUL: begin
				div_req.start = mul_rsp.done;
			end
			tsq_pkg::ST_NDIV: begin
				div_req.start    = div_rsp.done && !n_zero && (freq_q != '0);
				div_req.dividend = tsq_pkg::DIV_W'(rate_q);
				div_req.divisor  = tsq_pkg::DIVR_W'(freq_q);
			end
			tsq_pkg::ST_PDIV: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = tsq_pkg::DIV_W'(idx_q);
				div_req.divisor  = tsq_pkg::DIVR_W'(per_cl);
			end
			tsq_pkg::ST_PHDIV: begin
				div_req.start = 1'b0;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsq_pkg::ST_IDLE;
			rate_q      <= tsq_pkg::RATE_RST;
			amp_q       <= tsq_pkg::AMP_RST;
			mid_q       <= tsq_pkg::MID_RST;
			maxs_q      <= tsq_pkg::MAXS_RST;
			idx_q       <= '0;
			remain_q    <= '0;
			period_q    <= tsq_pkg::MIN_PER;
			half_q      <= tsq_pkg::HALF_W'(1);
			phase_q     <= '0;
			silent_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_addr)
					tsq_pkg::REG_SAMPLE_RATE: rate_q <= cfg_wdata[tsq_pkg::RATE_W-1:0];
					tsq_pkg::REG_AMPLITUDE:   amp_q  <= cfg_wdata[tsq_pkg::AMP_W-1:0];
					tsq_pkg::REG_MIDPOINT:    mid_q  <= cfg_wdata[tsq_pkg::MID_W-1:0];
					tsq_pkg::REG_MAX_SAMPLES: maxs_q <= cfg_wdata[tsq_pkg::MAXS_W-1:0];
					default: ;
				endcase
			end

			if (in_acc && kind_tick) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc && kind_tick) begin
				if (remain_q != '0) begin
					remain_q <= remain_q - 1'b1;
					idx_q    <= idx_next;
					if (!silent_q) begin
						phase_q <= (phase_inc >= period_q) ? '0 : phase_inc;
					end
				end
			end else if (in_acc && restart) begin
				idx_q    <= '0;
				remain_q <= '0;
			end

			// silent step commits after the length division
			if (state_q == tsq_pkg::ST_NDIV && div_rsp.done && !n_zero && freq_q == '0) begin
				remain_q <= n_clip;
				silent_q <= 1'b1;
			end

			if (state_q == tsq_pkg::ST_PHDIV && div_rsp.done) begin
				remain_q <= nstep_q;
				silent_q <= 1'b0;
				period_q <= per_new_q;
				half_q   <= per_new_q[tsq_pkg::PER_W-1:1];
				phase_q  <= div_rsp.remainder;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !kind_tick) freq_q <= in_freq;
		if (state_q == tsq_pkg::ST_NDIV && div_rsp.done) nstep_q <= n_clip;
		if (state_q == tsq_pkg::ST_PDIV && div_rsp.done) per_new_q <= per_cl;
		if (in_acc && kind_tick) begin
			out_sample_q <= tick_sample;
			out_active_q <= tick_active;
			out_full_q   <= tick_full;
		end
	end

	tsq_sermul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	tsq_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sample_q;
	assign m_axis_tuser  = {out_full_q, out_active_q};

endmodule

// ===== src/tsq_checker.sv =====
// ---------------------------------------------------------------------------
// tsq_checker
// port-level checks of the square tone sequencer, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tsq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [1:0]                  s_axis_tuser,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [15:0]                 m_axis_tdata,
	input logic [1:0]                  m_axis_tuser
);

	logic tick_acc;
	logic step_acc;

	assign tick_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == tsq_pkg::KIND_TICK);
	assign step_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == tsq_pkg::KIND_STEP);

	// a stalled result holds
	`ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// every tick item gives a result item in the next cycle
	`ASSERT_NXT(a_tick_result, clk, arst_n, tick_acc, m_axis_tvalid)

	// a step item leaves the input side not ready right after it is taken
	`ASSERT_NXT(a_step_busy, clk, arst_n, step_acc, !s_axis_tready)

	// a fresh result only follows a tick item
	`ASSERT_IMP(a_no_invented, clk, arst_n, $rose(m_axis_tvalid),
		$past(tick_acc))

endmodule

bind square_tone_sequencer tsq_checker u_tsq_checker (.*);

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// square tone sequencer testbench
// drives step and tick items through the stream input, predicts every sample
// from a behavioural copy of the sequencer and checks each output item in order;
// runs directed corner items, then random sequences over several register settings
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tsq_pkg::*;

	localparam int LIMIT         = 500000;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_SHOWN     = 30;

	typedef struct {
		item_kind_t        kind;
		logic              restart;
		logic [FREQ_W-1:0] freq;
		logic [MS_W-1:0]   ms;
	} tone_item_t;

	typedef struct {
		logic [15:0] level;
		logic        active;
		logic        full;
	} dac_sample_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [31:0]        s_axis_tdata = '0;  // freq_hz, step_ms
	logic [1:0]         s_axis_tuser = '0;  // kind, restart
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [15:0]        m_axis_tdata;       // sample
	logic [1:0]         m_axis_tuser;       // active, budget_full
	logic               cfg_we = 1'b0;
	logic [ADDR_W-1:0]  cfg_addr = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;

	// register copies
	logic [RATE_W-1:0] rate_q = RATE_RST;
	logic [AMP_W-1:0]  amp_q  = AMP_RST;
	logic [MID_W-1:0]  mid_q  = MID_RST;
	logic [MAXS_W-1:0] maxs_q = MAXS_RST;

	// sequencer state as predicted
	logic [COUNT_BITS-1:0] seq_index = '0;
	logic [COUNT_BITS-1:0] step_left = '0;
	logic [PER_W-1:0]      period    = PER_W'(2);
	logic [HALF_W-1:0]     half      = HALF_W'(1);
	logic [PER_W-1:0]      phase     = '0;
	logic                  silent    = 1'b1;

	tone_item_t  pending_items[$];
	dac_sample_t expected_samples[$];
	tone_item_t  tx_cur;
	dac_sample_t want;

	int items_queued = 0;
	int items_taken = 0;
	int steps_taken = 0;
	int results_checked = 0;
	int settings_used = 1;
	int errors = 0;
	int cycle_count = 0;
	int hold_asks = 0;
	int holds_done = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	int hold_left = 0;
	logic calm = 1'b0;

	square_tone_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// advances the tone state by one accepted item and queues the sample a tick item gives
	function automatic void play_item(tone_item_t it);
		longint unsigned n;
		longint unsigned budget;
		logic [PER_W-1:0] per;
		dac_sample_t r;
		int lvl;
		if (it.kind == KIND_STEP) begin
			steps_taken++;
			if (it.restart) begin
				seq_index = '0;
				step_left = '0;
			end
			n = (64'(rate_q) * 64'(it.ms)) / 64'd1000;
			budget = (64'(maxs_q) > 64'(seq_index)) ? 64'(maxs_q) - 64'(seq_index) : 64'd0;
			if (n > budget)
				n = budget;
			// a step of zero length leaves the running step alone
			if (n != 0) begin
				step_left = n[COUNT_BITS-1:0];
				if (it.freq == 0) begin
					silent = 1'b1;
				end else begin
					per = rate_q / RATE_W'(it.freq);
					if (per < 2)
						per = PER_W'(2);
					silent = 1'b0;
					period = per;
					half = per[PER_W-1:1];
					phase = PER_W'(64'(seq_index) % 64'(per));
				end
			end
		end else begin
			if (step_left == 0) begin
				r.level = mid_q;
				r.active = 1'b0;
			end else begin
				if (silent)
					lvl = int'(mid_q);
				else if (phase < half)
					lvl = int'(mid_q) + int'(amp_q);
				else
					lvl = int'(mid_q) - int'(amp_q);
				if (lvl < 0)
					lvl = 0;
				else if (lvl > 65535)
					lvl = 65535;
				r.level = 16'(lvl);
				r.active = 1'b1;
				if (!silent) begin
					phase++;
					if (phase >= period)
						phase = '0;
				end
				if (seq_index != '1)
					seq_index++;
				step_left--;
			end
			r.full = (seq_index >= maxs_q);
			expected_samples.push_back(r);
		end
	endfunction

	function automatic void compare_field(string what, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%0t ns: %s expected %0h got %0h", $time, what, exp_v, got_v);
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_idle <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				play_item(tx_cur);
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_idle != 0) begin
					tx_idle <= tx_idle - 1;
					s_axis_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 11) == 0) begin
					tx_idle <= $urandom_range(0, 8);
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					tx_cur = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {tx_cur.ms, tx_cur.freq};
					s_axis_tuser <= {tx_cur.restart, tx_cur.kind};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_idle <= 0;
			hold_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("%0t ns: sample %0h arrived with nothing expected",
							$time, m_axis_tdata);
				end else begin
					want = expected_samples.pop_front();
					compare_field("sample", 32'(want.level), 32'(m_axis_tdata));
					compare_field("active", 32'(want.active), 32'(m_axis_tuser[0]));
					compare_field("budget_full", 32'(want.full), 32'(m_axis_tuser[1]));
					results_checked++;
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (holds_done < hold_asks) begin
				// long back-pressure so the block fills and stalls its input
				holds_done++;
				hold_left <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (rx_idle != 0) begin
				rx_idle <= rx_idle - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				rx_idle <= $urandom_range(0, 8);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic add_item(item_kind_t kind, logic restart, logic [FREQ_W-1:0] freq,
			logic [MS_W-1:0] ms);
		tone_item_t it;
		it.kind = kind;
		it.restart = restart;
		it.freq = freq;
		it.ms = ms;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic add_tick();
		add_item(KIND_TICK, 1'($urandom), FREQ_W'($urandom), MS_W'($urandom));
	endtask

	// wait until every item is in and every sample is out, then let a step finish
	task automatic settle();
		while (items_taken < items_queued || expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SAMPLE_RATE: rate_q = val[RATE_W-1:0];
			REG_AMPLITUDE:   amp_q  = val[AMP_W-1:0];
			REG_MIDPOINT:    mid_q  = val[MID_W-1:0];
			REG_MAX_SAMPLES: maxs_q = val[MAXS_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(int unsigned rate, int unsigned amp, int unsigned mid,
			int unsigned maxs);
		settle();
		write_reg(REG_SAMPLE_RATE, CFG_W'(rate));
		write_reg(REG_AMPLITUDE, CFG_W'(amp));
		write_reg(REG_MIDPOINT, CFG_W'(mid));
		write_reg(REG_MAX_SAMPLES, CFG_W'(maxs));
		settings_used++;
	endtask

	// mostly a step followed by a run of ticks, the rest loose items
	task automatic random_phase(int count, int ms_max);
		int made;
		int ticks;
		int div;
		int unsigned q;
		logic [FREQ_W-1:0] f;
		logic [MS_W-1:0] d;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 7))
					0: f = '0;
					1: f = FREQ_W'($urandom);
					default: begin
						// short periods so both halves show up within a step
						div = $urandom_range(2, 24);
						q = rate_q / div;
						f = (q > 65535) ? '1 : FREQ_W'(q);
					end
				endcase
				if ($urandom_range(0, 7) == 0)
					d = MS_W'($urandom);
				else
					d = MS_W'($urandom_range(0, ms_max));
				add_item(KIND_STEP, $urandom_range(0, 5) == 0, f, d);
				ticks = $urandom_range(0, 14);
				repeat (ticks) add_tick();
				made += 1 + ticks;
			end else begin
				add_item(item_kind_t'($urandom_range(0, 1)), 1'($urandom),
					FREQ_W'($urandom), MS_W'($urandom));
				made++;
			end
		end
	endtask

	initial begin
		int unsigned rate;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items on the reset settings
		add_tick();                                       // idle tick
		add_item(KIND_TICK, 1'b1, '1, '1);                // restart on a tick does nothing
		add_item(KIND_STEP, 1'b1, 16'd20000, 16'd0);      // zero length, skipped
		add_item(KIND_STEP, 1'b0, 16'd20000, 16'd1);      // period 4
		repeat (6) add_tick();
		add_item(KIND_STEP, 1'b0, 16'd0, 16'd1);          // silence replaces running step
		repeat (2) add_tick();
		add_item(KIND_STEP, 1'b0, '1, '1);                // period clamps to 2, length clipped
		repeat (2) add_tick();
		add_item(KIND_STEP, 1'b0, 16'd1, '1);             // longest period
		repeat (2) add_tick();
		add_item(KIND_STEP, 1'b1, 16'd20000, 16'd0);      // restart with skipped step
		repeat (2) add_tick();

		// clamp high, small budget so it runs out
		set_regs(1000, 32767, 65535, 40);
		random_phase(45, 12);
		settle();
		random_phase(45, 12);

		set_regs(200000, 0, 0, 1048575);
		random_phase(50, 1);

		// tiny rate: period often clamped, clamp low; receiver stalls for a while
		set_regs(7, 12000, 0, 300);
		hold_asks++;
		add_item(KIND_STEP, 1'b1, 16'd1, '1);
		repeat (40) add_tick();
		random_phase(40, 65535);

		// no budget at all
		set_regs(1000, 500, 1234, 0);
		random_phase(25, 12);

		repeat (2) begin
			rate = $urandom_range(1000, 200000);
			set_regs(rate, $urandom_range(0, 32767), $urandom_range(0, 65535),
				$urandom_range(20, 2000));
			random_phase(50, 16000 / rate + 1);
		end

		set_regs(1000, $urandom_range(0, 32767), $urandom_range(0, 65535), 1048575);
		calm = 1'b1;
		random_phase(40, 12);
		settle();

		$display("covered %0d items (%0d tone steps) and %0d checked samples", items_taken,
			steps_taken, results_checked);
		$display("over %0d register settings, %0d long output stalls", settings_used,
			holds_done);
		if (errors == 0 && expected_samples.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/tsq_pkg.sv
src/tsq_sermul.sv
src/tsq_serdiv.sv
src/square_tone_sequencer.sv
src/tsq_checker.sv
tb/sv/testbench.sv
